@@ hw/rtl/hdl_source_tokenizer_unit_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef HDL_SOURCE_TOKENIZER_UNIT_DEFINES_SVH
`define HDL_SOURCE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HSTOK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, checked outside reset.
`define HSTOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

@@ hw/rtl/hstok_pkg.sv @@
// Package for the source tokenizer: word types, scan modes, token kinds,
// character constants and character-class functions. No dependencies.
`default_nettype none

package hstok_pkg;

  localparam int POS_WIDTH  = 20;
  localparam int LINE_WIDTH = 16;

  localparam logic [POS_WIDTH-1:0]  POS_MAX  = '1;
  localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;

  // Token kinds
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_SYMBOL = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // Characters with a role of their own
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEL       = 8'h85;
  localparam logic [7:0] CH_NBSP      = 8'hA0;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_TICK      = 8'h27;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_EQ        = 8'h3D;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_QMARK     = 8'h3F;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BAR       = 8'h7C;

  typedef enum logic [7:0] {
    MODE_NORMAL     = 8'b0000_0001,
    MODE_IDENT      = 8'b0000_0010,
    MODE_NUMBER     = 8'b0000_0100,
    MODE_STRING     = 8'b0000_1000,
    MODE_ESCAPE     = 8'b0001_0000,
    MODE_LINE       = 8'b0010_0000,
    MODE_BLOCK      = 8'b0100_0000,
    MODE_BLOCK_STAR = 8'b1000_0000
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]            token_kind;
    logic [POS_WIDTH-1:0]  start_pos;
    logic [POS_WIDTH-1:0]  end_pos;
    logic [LINE_WIDTH-1:0] token_line;
    logic [LINE_WIDTH-1:0] token_column;
    logic                  run_last;
  } out_word_t;

  // One pending token record
  typedef struct packed {
    logic [2:0]            kind;
    logic [POS_WIDTH-1:0]  start_pos;
    logic [POS_WIDTH-1:0]  end_pos;
    logic [LINE_WIDTH-1:0] line;
    logic [LINE_WIDTH-1:0] column;
  } tok_rec_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE || c == CH_NEL || c == CH_NBSP;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic ident_first(input logic [7:0] c);
    return c == CH_UNDERSCORE || c == CH_DOLLAR ||
           (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic ident_more(input logic [7:0] c);
    return ident_first(c) || is_digit(c);
  endfunction

  function automatic logic number_more(input logic [7:0] c);
    return ident_more(c) || c == CH_TICK || c == CH_QMARK;
  endfunction

  function automatic logic needs_lookahead(input logic [7:0] c);
    return c == CH_SLASH || c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG ||
           c == CH_AMP || c == CH_BAR || c == CH_PLUS || c == CH_MINUS || c == CH_COLON;
  endfunction

  function automatic logic forms_pair(input logic [7:0] a, input logic [7:0] b);
    logic rel;
    logic dbl;
    rel = (a == CH_LT || a == CH_GT || a == CH_EQ || a == CH_BANG) && b == CH_EQ;
    dbl = (a == b) && (a == CH_AMP || a == CH_BAR || a == CH_PLUS ||
                       a == CH_MINUS || a == CH_COLON);
    return rel || dbl;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hdl_source_tokenizer_unit.sv @@
// Source tokenizer top level: byte-wide lexer state, counters and a
// three-slot token buffer. Depends on hstok_pkg and the defines header.
//
//   channel | signals                      | word
//   in      | in_valid, in_ready, in_data  | one source byte and end-of-text flag
//   out     | out_valid, out_ready, out_data | one token record
//
// A byte is taken in the cycle it is offered while the token buffer is free
// or is emptied by the word leaving in that same cycle.
// A byte that yields more than one token (up to three) holds the input until its
// last token word leaves, at one output word per cycle while out_ready is high;
// bytes yielding one or none stream at one per cycle unless the output stalls.
// Reset clears the scan state and counters at once; no clearing pass.
// A stalled output keeps its word; the input simply stays not ready.
`default_nettype none
`include "hdl_source_tokenizer_unit_defines.svh"

module hdl_source_tokenizer_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hstok_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output hstok_pkg::out_word_t      out_data
);
  import hstok_pkg::*;

  // Scan state
  scan_mode_t            mode;
  logic [7:0]            held_char;
  logic                  held_valid;
  logic [POS_WIDTH-1:0]  token_start;
  logic [LINE_WIDTH-1:0] token_start_line;
  logic [LINE_WIDTH-1:0] token_start_column;
  logic [POS_WIDTH-1:0]  byte_offset;
  logic [LINE_WIDTH-1:0] line_counter;
  logic [LINE_WIDTH-1:0] column_counter;

  // Token buffer: slot 0 closes before the byte, slot 1 after it, slot 2 is the end marker
  tok_rec_t   slot [3];
  logic [2:0] pend;

  scan_mode_t            mode_next;
  logic [7:0]            held_char_next;
  logic                  held_valid_next;
  logic [POS_WIDTH-1:0]  token_start_next;
  logic [LINE_WIDTH-1:0] token_start_line_next;
  logic [LINE_WIDTH-1:0] token_start_column_next;
  logic [POS_WIDTH-1:0]  off_a;
  logic [LINE_WIDTH-1:0] line_a;
  logic [LINE_WIDTH-1:0] col_a;

  logic       a_vld;
  logic [2:0] a_kind;
  logic       bc_vld;
  logic [2:0] bc_kind;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] sel;
  logic [2:0] pop;
  logic [7:0] c;

  assign c = in_data.char_code;

  // Advance counters by one byte, saturating
  always @* begin
    off_a  = (byte_offset == POS_MAX) ? byte_offset : byte_offset + 1'b1;
    line_a = line_counter;
    col_a  = column_counter;
    if (c == CH_NEWLINE) begin
      line_a = (line_counter == LINE_MAX) ? line_counter : line_counter + 1'b1;
      col_a  = LINE_WIDTH'(1);
    end else if (c != CH_CR) begin
      col_a  = (column_counter == LINE_MAX) ? column_counter : column_counter + 1'b1;
    end
  end

  // Lex one byte: pending token close, mode step, end-of-text flush
  always @* begin
    logic       pair;
    logic       open_line;
    logic       open_block;
    logic       taken;
    logic       ident_end;
    logic       number_end;
    logic       b_vld;
    logic       c_vld;
    logic [2:0] c_kind;
    scan_mode_t mode_eff;

    pair       = held_valid && forms_pair(held_char, c);
    open_line  = held_valid && held_char == CH_SLASH && c == CH_SLASH;
    open_block = held_valid && held_char == CH_SLASH && c == CH_STAR;
    taken      = pair || open_line || open_block;
    ident_end  = (mode == MODE_IDENT) && !ident_more(c);
    number_end = (mode == MODE_NUMBER) && !number_more(c);

    a_vld  = (held_valid && !taken) || ident_end || number_end;
    a_kind = ident_end ? KIND_IDENT : (number_end ? KIND_NUMBER : KIND_SYMBOL);

    mode_eff = (ident_end || number_end) ? MODE_NORMAL : mode;

    mode_next               = mode_eff;
    held_valid_next         = 1'b0;
    held_char_next          = '0;
    token_start_next        = token_start;
    token_start_line_next   = token_start_line;
    token_start_column_next = token_start_column;
    b_vld                   = 1'b0;
    bc_kind                 = KIND_SYMBOL;

    if (taken) begin
      b_vld     = pair;
      mode_next = open_line ? MODE_LINE : (open_block ? MODE_BLOCK : MODE_NORMAL);
    end else begin
      case (mode_eff)
        MODE_IDENT, MODE_NUMBER: begin
          mode_next = mode_eff;
        end
        MODE_STRING: begin
          if (c == CH_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else if (c == CH_QUOTE) begin
            b_vld     = 1'b1;
            bc_kind   = KIND_STRING;
            mode_next = MODE_NORMAL;
          end
        end
        MODE_ESCAPE: begin
          mode_next = MODE_STRING;
        end
        MODE_LINE: begin
          if (c == CH_NEWLINE) begin
            mode_next = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) begin
            mode_next = MODE_BLOCK_STAR;
          end
        end
        MODE_BLOCK_STAR: begin
          if (c == CH_SLASH) begin
            mode_next = MODE_NORMAL;
          end else if (c != CH_STAR) begin
            mode_next = MODE_BLOCK;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          if (!is_space(c)) begin
            token_start_next        = byte_offset;
            token_start_line_next   = line_counter;
            token_start_column_next = column_counter;
            if (c == CH_QUOTE) begin
              mode_next = MODE_STRING;
            end else if (ident_first(c)) begin
              mode_next = MODE_IDENT;
            end else if (is_digit(c)) begin
              mode_next = MODE_NUMBER;
            end else if (needs_lookahead(c)) begin
              held_valid_next = 1'b1;
              held_char_next  = c;
            end else begin
              b_vld = 1'b1;
            end
          end
        end
      endcase
    end

    // Flush a held symbol or an open identifier, number or string at end of text
    c_vld  = 1'b0;
    c_kind = KIND_SYMBOL;
    if (in_data.text_end) begin
      if (held_valid_next) begin
        c_vld = 1'b1;
      end else if (mode_next == MODE_IDENT) begin
        c_vld  = 1'b1;
        c_kind = KIND_IDENT;
      end else if (mode_next == MODE_NUMBER) begin
        c_vld  = 1'b1;
        c_kind = KIND_NUMBER;
      end else if (mode_next == MODE_STRING || mode_next == MODE_ESCAPE) begin
        c_vld  = 1'b1;
        c_kind = KIND_STRING;
      end
    end

    bc_vld = b_vld || c_vld;
    if (!b_vld) begin
      bc_kind = c_kind;
    end
  end

  // Pick the oldest pending word
  always @* begin
    if (pend[0]) begin
      sel = 2'd0;
    end else if (pend[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign out_valid = |pend;
  assign out_fire  = out_valid && out_ready;
  assign pop       = out_fire ? (3'b001 << sel) : 3'b000;
  assign in_ready  = (pend & ~pop) == 3'b000;
  assign in_fire   = in_valid && in_ready;

  always @* begin
    out_data.token_kind   = slot[sel].kind;
    out_data.start_pos    = slot[sel].start_pos;
    out_data.end_pos      = slot[sel].end_pos;
    out_data.token_line   = slot[sel].line;
    out_data.token_column = slot[sel].column;
    case (sel)
      2'd0:    out_data.run_last = !(pend[1] || pend[2]);
      2'd1:    out_data.run_last = !pend[2];
      default: out_data.run_last = 1'b1;
    endcase
  end

  // Update scan state on each accepted byte; retire token words as they leave
  always @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_NORMAL;
      held_char          <= '0;
      held_valid         <= 1'b0;
      token_start        <= '0;
      token_start_line   <= LINE_WIDTH'(1);
      token_start_column <= LINE_WIDTH'(1);
      byte_offset        <= '0;
      line_counter       <= LINE_WIDTH'(1);
      column_counter     <= LINE_WIDTH'(1);
      pend               <= 3'b000;
    end else begin
      pend <= pend & ~pop;
      if (in_fire) begin
        pend <= {in_data.text_end, bc_vld, a_vld};
        if (in_data.text_end) begin
          mode               <= MODE_NORMAL;
          held_char          <= '0;
          held_valid         <= 1'b0;
          token_start        <= '0;
          token_start_line   <= LINE_WIDTH'(1);
          token_start_column <= LINE_WIDTH'(1);
          byte_offset        <= '0;
          line_counter       <= LINE_WIDTH'(1);
          column_counter     <= LINE_WIDTH'(1);
        end else begin
          mode               <= mode_next;
          held_char          <= held_char_next;
          held_valid         <= held_valid_next;
          token_start        <= token_start_next;
          token_start_line   <= token_start_line_next;
          token_start_column <= token_start_column_next;
          byte_offset        <= off_a;
          line_counter       <= line_a;
          column_counter     <= col_a;
        end
      end
    end
  end

  // Load token records; payload needs no reset
  always @(posedge clk) begin
    if (in_fire) begin
      slot[0] <= '{kind: a_kind, start_pos: token_start, end_pos: byte_offset,
                   line: token_start_line, column: token_start_column};
      slot[1] <= '{kind: bc_kind, start_pos: token_start_next, end_pos: off_a,
                   line: token_start_line_next, column: token_start_column_next};
      slot[2] <= '{kind: KIND_END, start_pos: off_a, end_pos: off_a,
                   line: line_a, column: col_a};
    end
  end

  // Checks
  `HSTOK_ASSERT_NOW(a_busy_blocks_input, $countones(pend) > 1, !in_ready)
  `HSTOK_ASSERT_NOW(a_held_only_normal, held_valid, mode == MODE_NORMAL)
  `HSTOK_ASSERT_NEXT(a_end_resets_state, in_fire && in_data.text_end, byte_offset == '0 && !held_valid && mode == MODE_NORMAL && line_counter == LINE_WIDTH'(1))
  `HSTOK_ASSERT_NEXT(a_end_marker_queued, in_fire && in_data.text_end, pend[2] && slot[2].kind == KIND_END)

endmodule

`default_nettype wire

@@ tb/hdl_source_tokenizer_unit_tb.sv @@
// Self-checking bench for hdl_source_tokenizer_unit: feeds source bytes, predicts token words
// and compares them in order. Depends on hstok_pkg and the tokenizer RTL.
`default_nettype none

module hdl_source_tokenizer_unit_tb;
  import hstok_pkg::*;

  localparam int RANDOM_BYTES   = 230;
  localparam int FEED_DEPTH     = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PRINT_LIMIT    = 40;

  typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_SPARSE, RX_CADENCE} rx_style_t;
  typedef enum logic [2:0] {
    FR_WORD, FR_NUMBER, FR_STRING, FR_BLANK, FR_LINE_NOTE, FR_BLOCK_NOTE, FR_PAIR, FR_NOISE
  } frag_kind_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  hdl_source_tokenizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  in_word_t    source_bytes[$];
  logic [7:0]  fragment[$];
  out_word_t   expected_tokens[$];
  logic        word_taken = 1'b0;
  int          fail_count = 0;
  int          token_count = 0;
  int          quiet_cycles = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          stall_span = 0;
  int          rx_tick = 0;
  rx_style_t   rx_style = RX_OPEN;

  // Lexer prediction state
  scan_mode_t            lx_mode;
  logic [7:0]            lx_held;
  logic                  lx_held_ok;
  logic [POS_WIDTH-1:0]  lx_tok_start;
  logic [LINE_WIDTH-1:0] lx_tok_line;
  logic [LINE_WIDTH-1:0] lx_tok_col;
  logic [POS_WIDTH-1:0]  lx_offset;
  logic [LINE_WIDTH-1:0] lx_line;
  logic [LINE_WIDTH-1:0] lx_col;
  out_word_t             burst_words[3];
  int                    burst_n;

  function automatic logic blank_byte(input logic [7:0] c);
    case (c)
      8'h09, CH_NEWLINE, 8'h0B, 8'h0C, CH_CR, CH_SPACE, CH_NEL, CH_NBSP: blank_byte = 1'b1;
      default: blank_byte = 1'b0;
    endcase
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_head(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return (folded >= "a" && folded <= "z") || c == CH_UNDERSCORE || c == CH_DOLLAR;
  endfunction

  function automatic logic word_body(input logic [7:0] c);
    return word_head(c) || digit_byte(c);
  endfunction

  function automatic logic num_body(input logic [7:0] c);
    return word_body(c) || c == CH_TICK || c == CH_QMARK;
  endfunction

  function automatic logic pair_lead(input logic [7:0] c);
    case (c)
      CH_SLASH, CH_LT, CH_GT, CH_EQ, CH_BANG, CH_AMP, CH_BAR, CH_PLUS, CH_MINUS, CH_COLON:
        pair_lead = 1'b1;
      default: pair_lead = 1'b0;
    endcase
  endfunction

  function automatic logic joins(input logic [7:0] a, input logic [7:0] b);
    case (a)
      CH_LT, CH_GT, CH_EQ, CH_BANG: joins = (b == CH_EQ);
      CH_AMP, CH_BAR, CH_PLUS, CH_MINUS, CH_COLON: joins = (b == a);
      default: joins = 1'b0;
    endcase
  endfunction

  task automatic clear_lexer();
    lx_mode      = MODE_NORMAL;
    lx_held      = '0;
    lx_held_ok   = 1'b0;
    lx_tok_start = '0;
    lx_tok_line  = LINE_WIDTH'(1);
    lx_tok_col   = LINE_WIDTH'(1);
    lx_offset    = '0;
    lx_line      = LINE_WIDTH'(1);
    lx_col       = LINE_WIDTH'(1);
  endtask

  // Advance offset, line and column past one byte, saturating
  task automatic step_counters(input logic [7:0] c);
    if (lx_offset != POS_MAX) lx_offset = lx_offset + 1'b1;
    if (c == CH_NEWLINE) begin
      if (lx_line != LINE_MAX) lx_line = lx_line + 1'b1;
      lx_col = LINE_WIDTH'(1);
    end else if (c != CH_CR) begin
      if (lx_col != LINE_MAX) lx_col = lx_col + 1'b1;
    end
  endtask

  task automatic mark_token();
    lx_tok_start = lx_offset;
    lx_tok_line  = lx_line;
    lx_tok_col   = lx_col;
  endtask

  task automatic add_token(input logic [2:0] kind, input logic [POS_WIDTH-1:0] s,
                           input logic [POS_WIDTH-1:0] e, input logic [LINE_WIDTH-1:0] ln,
                           input logic [LINE_WIDTH-1:0] cl);
    out_word_t rec;
    rec.token_kind   = kind;
    rec.start_pos    = s;
    rec.end_pos      = e;
    rec.token_line   = ln;
    rec.token_column = cl;
    rec.run_last     = 1'b0;
    if (burst_n < 3) begin
      burst_words[burst_n] = rec;
      burst_n++;
    end
  endtask

  task automatic close_token(input logic [2:0] kind);
    add_token(kind, lx_tok_start, lx_offset, lx_tok_line, lx_tok_col);
  endtask

  // Run one byte through the scan modes; a finished word or line comment hands it back
  task automatic scan_byte(input logic [7:0] c);
    logic again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lx_mode)
        MODE_IDENT, MODE_NUMBER: begin
          if ((lx_mode == MODE_IDENT) ? word_body(c) : num_body(c)) begin
            step_counters(c);
          end else begin
            close_token((lx_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER);
            lx_mode = MODE_NORMAL;
            again = 1'b1;
          end
        end
        MODE_STRING: begin
          step_counters(c);
          if (c == CH_BACKSLASH) begin
            lx_mode = MODE_ESCAPE;
          end else if (c == CH_QUOTE) begin
            close_token(KIND_STRING);
            lx_mode = MODE_NORMAL;
          end
        end
        MODE_ESCAPE: begin
          step_counters(c);
          lx_mode = MODE_STRING;
        end
        MODE_LINE: begin
          if (c == CH_NEWLINE) begin
            lx_mode = MODE_NORMAL;
            again = 1'b1;
          end else begin
            step_counters(c);
          end
        end
        MODE_BLOCK: begin
          step_counters(c);
          if (c == CH_STAR) lx_mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          step_counters(c);
          if (c == CH_SLASH) lx_mode = MODE_NORMAL;
          else if (c != CH_STAR) lx_mode = MODE_BLOCK;
        end
        default: begin
          lx_mode = MODE_NORMAL;
          if (blank_byte(c)) begin
            step_counters(c);
          end else begin
            mark_token();
            step_counters(c);
            if (c == CH_QUOTE) lx_mode = MODE_STRING;
            else if (word_head(c)) lx_mode = MODE_IDENT;
            else if (digit_byte(c)) lx_mode = MODE_NUMBER;
            else if (pair_lead(c)) begin
              lx_held    = c;
              lx_held_ok = 1'b1;
            end else close_token(KIND_SYMBOL);
          end
        end
      endcase
    end
  endtask

  // Predict the token words caused by one accepted source word
  task automatic lex_word(input in_word_t w);
    logic [7:0] c;
    logic       take;
    out_word_t  rec;
    c = w.char_code;
    take = 1'b1;
    burst_n = 0;
    if (lx_held_ok) begin
      lx_held_ok = 1'b0;
      if (joins(lx_held, c)) begin
        step_counters(c);
        close_token(KIND_SYMBOL);
        take = 1'b0;
      end else if (lx_held == CH_SLASH && c == CH_SLASH) begin
        step_counters(c);
        lx_mode = MODE_LINE;
        take = 1'b0;
      end else if (lx_held == CH_SLASH && c == CH_STAR) begin
        step_counters(c);
        lx_mode = MODE_BLOCK;
        take = 1'b0;
      end else begin
        close_token(KIND_SYMBOL);
      end
      lx_held = '0;
    end
    if (take) scan_byte(c);
    // Flush any open token, then the end marker
    if (w.text_end) begin
      if (lx_held_ok) close_token(KIND_SYMBOL);
      if (lx_mode == MODE_IDENT) close_token(KIND_IDENT);
      else if (lx_mode == MODE_NUMBER) close_token(KIND_NUMBER);
      else if (lx_mode == MODE_STRING || lx_mode == MODE_ESCAPE) close_token(KIND_STRING);
      add_token(KIND_END, lx_offset, lx_offset, lx_line, lx_col);
      clear_lexer();
    end
    for (int i = 0; i < burst_n; i++) begin
      rec = burst_words[i];
      rec.run_last = (i == burst_n - 1);
      expected_tokens.push_back(rec);
    end
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("token %0d: %s", token_count, msg);
  endtask

  task automatic check_token(input out_word_t got);
    out_word_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("kind %0d start %0d with none expected",
                                got.token_kind, got.start_pos));
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
        report_mismatch($sformatf("token_kind %0d, expected %0d",
                                  got.token_kind, want.token_kind));
      if (got.start_pos !== want.start_pos)
        report_mismatch($sformatf("start_pos %0d, expected %0d",
                                  got.start_pos, want.start_pos));
      if (got.end_pos !== want.end_pos)
        report_mismatch($sformatf("end_pos %0d, expected %0d", got.end_pos, want.end_pos));
      if (got.token_line !== want.token_line)
        report_mismatch($sformatf("token_line %0d, expected %0d",
                                  got.token_line, want.token_line));
      if (got.token_column !== want.token_column)
        report_mismatch($sformatf("token_column %0d, expected %0d",
                                  got.token_column, want.token_column));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("run_last %0d, expected %0d", got.run_last, want.run_last));
    end
    token_count++;
  endtask

  // Monitor: predict on accepted source words, check token words, watch for a hang
  always @(posedge clk) begin
    word_taken = in_valid && in_ready;
    if (rst) begin
      clear_lexer();
      quiet_cycles = 0;
    end else begin
      if (word_taken) lex_word(in_data);
      if (out_valid && out_ready) check_token(out_data);
      if (word_taken || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Driver: offer source words in bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (source_bytes.size() != 0) begin
        in_data  <= source_bytes.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall styles every stretch of cycles
  always @(negedge clk) begin
    logic ready_next;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      if (stall_span == 0) begin
        rx_style   = rx_style_t'($urandom_range(0, 3));
        stall_span = $urandom_range(20, 200);
      end else begin
        stall_span--;
      end
      case (rx_style)
        RX_OPEN:    ready_next = 1'b1;
        RX_BUSY:    ready_next = ($urandom_range(0, 3) != 0);
        RX_SPARSE:  ready_next = ($urandom_range(0, 3) == 0);
        default:    ready_next = ((rx_tick % 3) != 2);
      endcase
      out_ready <= ready_next;
    end
  end

  // Hold the feed queue short so long texts stream in
  task automatic queue_byte(input logic [7:0] c, input logic last);
    in_word_t w;
    while (source_bytes.size() >= FEED_DEPTH) @(posedge clk);
    w.char_code = c;
    w.text_end  = last;
    source_bytes.push_back(w);
  endtask

  task automatic flush_fragment(input logic last);
    for (int i = 0; i < fragment.size(); i++)
      queue_byte(fragment[i], last && (i == fragment.size() - 1));
    fragment.delete();
  endtask

  function automatic logic [7:0] rand_word_char(input logic with_digits);
    if (with_digits && $urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    case ($urandom_range(0, 3))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("a" + $urandom_range(0, 25));
      2:       return CH_UNDERSCORE;
      default: return CH_DOLLAR;
    endcase
  endfunction

  initial begin : stimulus
    int         sent;
    int         n;
    logic [7:0] lead;
    frag_kind_t kind;

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: null byte, joined pair, block comment whose opening star does not
    // close it, line comment, carriage return, identifier, high byte, number,
    // then an unclosed string with an escape cut off by the end of text
    fragment = '{8'h00, CH_LT, CH_EQ, CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_STAR,
                 CH_SLASH, CH_SLASH, CH_SLASH, "q", CH_NEWLINE, CH_CR, CH_DOLLAR, "9",
                 8'hFF, "7", CH_TICK, CH_QMARK, CH_QUOTE, CH_BACKSLASH, CH_QUOTE};
    flush_fragment(1'b1);
    // Held byte not joined, identifier pending at end
    fragment = '{CH_BANG, "x"};
    flush_fragment(1'b1);
    // Open comment dropped at end
    fragment = '{CH_SLASH, CH_STAR};
    flush_fragment(1'b1);
    // Held byte flushed at end
    queue_byte(CH_MINUS, 1'b1);

    // Random: mostly well-formed fragments, some noise
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      kind = frag_kind_t'($urandom_range(0, 7));
      case (kind)
        FR_WORD: begin
          fragment.push_back(rand_word_char(1'b0));
          n = $urandom_range(0, 6);
          repeat (n) fragment.push_back(rand_word_char(1'b1));
        end
        FR_NUMBER: begin
          fragment.push_back(8'("0" + $urandom_range(0, 9)));
          n = $urandom_range(0, 5);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0)
              fragment.push_back($urandom_range(0, 1) ? CH_TICK : CH_QMARK);
            else
              fragment.push_back(rand_word_char(1'b1));
          end
        end
        FR_STRING: begin
          fragment.push_back(CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) fragment.push_back(CH_BACKSLASH);
            fragment.push_back(8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 7) != 0) fragment.push_back(CH_QUOTE);
        end
        FR_BLANK: begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            case ($urandom_range(0, 7))
              0:       fragment.push_back(8'h09);
              1:       fragment.push_back(CH_NEWLINE);
              2:       fragment.push_back(8'h0B);
              3:       fragment.push_back(8'h0C);
              4:       fragment.push_back(CH_CR);
              5:       fragment.push_back(CH_NEL);
              6:       fragment.push_back(CH_NBSP);
              default: fragment.push_back(CH_SPACE);
            endcase
          end
        end
        FR_LINE_NOTE: begin
          fragment.push_back(CH_SLASH);
          fragment.push_back(CH_SLASH);
          n = $urandom_range(0, 5);
          repeat (n) fragment.push_back(8'($urandom_range(0, 255)));
          fragment.push_back(CH_NEWLINE);
        end
        FR_BLOCK_NOTE: begin
          fragment.push_back(CH_SLASH);
          fragment.push_back(CH_STAR);
          n = $urandom_range(0, 5);
          repeat (n) begin
            case ($urandom_range(0, 2))
              0:       fragment.push_back(CH_STAR);
              1:       fragment.push_back(CH_SLASH);
              default: fragment.push_back(8'($urandom_range(0, 255)));
            endcase
          end
          if ($urandom_range(0, 7) != 0) begin
            fragment.push_back(CH_STAR);
            fragment.push_back(CH_SLASH);
          end
        end
        FR_PAIR: begin
          case ($urandom_range(0, 9))
            0:       lead = CH_SLASH;
            1:       lead = CH_LT;
            2:       lead = CH_GT;
            3:       lead = CH_EQ;
            4:       lead = CH_BANG;
            5:       lead = CH_AMP;
            6:       lead = CH_BAR;
            7:       lead = CH_PLUS;
            8:       lead = CH_MINUS;
            default: lead = CH_COLON;
          endcase
          fragment.push_back(lead);
          case ($urandom_range(0, 3))
            0:       fragment.push_back(8'($urandom_range(0, 255)));
            1:       fragment.push_back(CH_EQ);
            default: fragment.push_back(lead);
          endcase
        end
        default: begin
          n = $urandom_range(1, 3);
          repeat (n) fragment.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      sent += fragment.size();
      flush_fragment($urandom_range(0, 9) == 0);
    end
    queue_byte(CH_SPACE, 1'b1);

    // Drain: all words accepted, all tokens back, then a short tail
    while (source_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hstok_pkg.sv
hw/rtl/hdl_source_tokenizer_unit.sv
tb/hdl_source_tokenizer_unit_tb.sv
